@@ hdl/mrfp_pkg.sv @@
// ----------------------------------------------------------------------------
// mrfp_pkg
// Shared types and codes of the meter reply frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mrfp_pkg;

	// frame bytes
	localparam logic [7:0] HEAD_BYTE = 8'h68;
	localparam logic [7:0] END_BYTE  = 8'h16;
	localparam logic [7:0] SCRAMBLE  = 8'h33;

	// configuration
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTROL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

	localparam logic [47:0] RST_ADDRESS = 48'h0;
	localparam logic [7:0]  RST_CONTROL = 8'h81;
	localparam logic [7:0]  RST_MAX_LEN = 8'h60;

	// parser phases
	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_ADDR  = 3'd1;
	localparam logic [2:0] PH_HEAD2 = 3'd2;
	localparam logic [2:0] PH_CTRL  = 3'd3;
	localparam logic [2:0] PH_LEN   = 3'd4;
	localparam logic [2:0] PH_DATA  = 3'd5;
	localparam logic [2:0] PH_CHECK = 3'd6;
	localparam logic [2:0] PH_END   = 3'd7;

	// result status codes
	localparam logic [3:0] ST_BUSY     = 4'd0;
	localparam logic [3:0] ST_OK       = 4'd1;
	localparam logic [3:0] ST_NO_START = 4'd2;
	localparam logic [3:0] ST_ADDRESS  = 4'd3;
	localparam logic [3:0] ST_HEAD2    = 4'd4;
	localparam logic [3:0] ST_CONTROL  = 4'd5;
	localparam logic [3:0] ST_LENGTH   = 4'd6;
	localparam logic [3:0] ST_CHECKSUM = 4'd7;
	localparam logic [3:0] ST_END      = 4'd8;

	typedef struct packed {
		logic [47:0] address;
		logic [7:0]  control;
		logic [7:0]  max_len;
	} cfg_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       restart;
	} item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic        data_valid;
		logic [7:0]  data_index;
		logic [7:0]  data_value;
		logic [15:0] identifier;
		logic [7:0]  reply_len;
	} result_t;

	// pipeline handshake between stages
	typedef struct packed {
		logic valid;
		logic advance;
	} pipe_ctl_t;

endpackage

`default_nettype wire

@@ hdl/mrfp_ifs.sv @@
// ----------------------------------------------------------------------------
// mrfp channel interfaces
// Byte request channel, result channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       restart;
	modport source (output valid, rx_byte, restart, input ready);
	modport sink   (input valid, rx_byte, restart, output ready);
endinterface

interface mrfp_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic        data_valid;
	logic [7:0]  data_index;
	logic [7:0]  data_value;
	logic [15:0] identifier;
	logic [7:0]  reply_len;
	modport source (output valid, status, data_valid, data_index, data_value,
		identifier, reply_len, input ready);
	modport sink   (input valid, status, data_valid, data_index, data_value,
		identifier, reply_len, output ready);
endinterface

interface mrfp_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [47:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/mrfp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mrfp_cfg_regs
// Register file for address, reply control byte and length limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfp_cfg_regs
	import mrfp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_valid,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [47:0]          wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.address <= RST_ADDRESS;
			cfg_q.control <= RST_CONTROL;
			cfg_q.max_len <= RST_MAX_LEN;
		end else if (wr_valid) begin
			unique case (wr_index)
				CFG_ADDRESS: cfg_q.address <= wr_data;
				CFG_CONTROL: cfg_q.control <= wr_data[7:0];
				CFG_MAX_LEN: cfg_q.max_len <= wr_data[7:0];
				default: ; // unmapped index, dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hdl/mrfp_in_stage.sv @@
// ----------------------------------------------------------------------------
// mrfp_in_stage
// Input register: captures one byte request and holds it until it moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfp_in_stage
	import mrfp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire item_t in_item,
	input  wire logic  advance,
	output pipe_ctl_t  ctl,
	output item_t      item_s1
);

	logic valid_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	assign ctl.valid   = valid_s1;
	assign ctl.advance = valid_s1 && advance;

endmodule

`default_nettype wire

@@ hdl/mrfp_parse_core.sv @@
// ----------------------------------------------------------------------------
// mrfp_parse_core
// Frame state and the one-byte step: checks, checksum, descrambling.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfp_parse_core
	import mrfp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire pipe_ctl_t ctl,
	input  wire item_t     item_s1,
	input  wire cfg_t      cfg,
	output result_t        result
);

	logic [2:0]  phase_q, phase_d, phase_cur;
	logic [7:0]  count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] ident_q, ident_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  b;
	logic [7:0]  want;
	logic [7:0]  count_nx;
	logic [7:0]  descr;

	assign b         = item_s1.rx_byte;
	assign phase_cur = item_s1.restart ? PH_HUNT : phase_q;
	assign descr     = b - SCRAMBLE;
	assign count_nx  = count_q + 8'd1;

	// expected address byte; counter outside 1..6 acts as 1
	always_comb begin
		unique case (count_q)
			8'd2:    want = cfg.address[15:8];
			8'd3:    want = cfg.address[23:16];
			8'd4:    want = cfg.address[31:24];
			8'd5:    want = cfg.address[39:32];
			8'd6:    want = cfg.address[47:40];
			default: want = cfg.address[7:0];
		endcase
	end

	always_comb begin
		phase_d = phase_cur;
		count_d = count_q;
		sum_d   = sum_q;
		ident_d = ident_q;
		len_d   = len_q;
		result  = '0;
		result.status = ST_BUSY;

		unique case (phase_cur)
			PH_HUNT: begin
				if (b != HEAD_BYTE) begin
					result.status = ST_NO_START;
				end else begin
					sum_d   = b;
					ident_d = '0;
					count_d = 8'd6;
					phase_d = PH_ADDR;
				end
			end
			PH_ADDR: begin
				if (b != want) begin
					result.status = ST_ADDRESS;
				end else begin
					sum_d = sum_q + b;
					if (count_q >= 8'd2 && count_q <= 8'd6) begin
						count_d = count_q - 8'd1;
					end else begin
						count_d = 8'd0;
						phase_d = PH_HEAD2;
					end
				end
			end
			PH_HEAD2: begin
				if (b != HEAD_BYTE) begin
					result.status = ST_HEAD2;
				end else begin
					sum_d   = sum_q + b;
					phase_d = PH_CTRL;
				end
			end
			PH_CTRL: begin
				if (b != cfg.control) begin
					result.status = ST_CONTROL;
				end else begin
					sum_d   = sum_q + b;
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				if (b > cfg.max_len) begin
					result.status = ST_LENGTH;
				end else begin
					sum_d   = sum_q + b;
					len_d   = b;
					count_d = 8'd0;
					phase_d = (b == 8'd0) ? PH_CHECK : PH_DATA;
				end
			end
			PH_DATA: begin
				sum_d = sum_q + b;
				if (count_q == 8'd0) begin
					ident_d[7:0] = descr;
				end else if (count_q == 8'd1) begin
					ident_d[15:8] = descr;
				end else begin
					result.data_valid = 1'b1;
					result.data_index = count_q - 8'd2;
					result.data_value = descr;
				end
				count_d = count_nx;
				if (count_nx >= len_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				if (b != sum_q) begin
					result.status = ST_CHECKSUM;
				end else begin
					phase_d = PH_END;
				end
			end
			PH_END: begin
				if (b != END_BYTE) begin
					result.status = ST_END;
				end else begin
					result.status     = ST_OK;
					result.identifier = ident_q;
					result.reply_len  = len_q;
				end
			end
			default: ;
		endcase

		if (result.status != ST_BUSY) begin
			phase_d = PH_HUNT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			sum_q   <= '0;
			ident_q <= '0;
			len_q   <= '0;
		end else if (ctl.advance) begin
			phase_q <= phase_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			ident_q <= ident_d;
			len_q   <= len_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/mrfp_out_stage.sv @@
// ----------------------------------------------------------------------------
// mrfp_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfp_out_stage
	import mrfp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire pipe_ctl_t ctl,
	input  wire result_t   result,
	output logic           advance,
	output logic           out_valid,
	input  wire logic      out_ready,
	output result_t        result_q
);

	logic valid_q;

	assign advance   = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			result_q <= result;
		end
	end

endmodule

`default_nettype wire

@@ hdl/meter_reply_frame_parser.sv @@
// ----------------------------------------------------------------------------
// meter_reply_frame_parser
// Byte-wise checker of meter reply frames with payload descrambling.
//
// Channels:
//   rx  - one received byte per request (rx_byte) plus restart, which drops
//         any frame in progress before the byte is handled.
//   res - exactly one result per byte: status (0 busy, 1 frame ok, 2..8
//         error kinds), an optional payload byte with its index, and the
//         identifier and length field on a good end byte.
//   cfg - register writes: 0 meter address, 1 reply control, 2 max length.
//         Always ready; other indexes are dropped. Write only while idle.
// Timing: each byte passes the input register, then the result register.
//   One byte per cycle while res is not held off; the parse state loop
//   (phase, counter, checksum) closes between input and result registers.
// Reset: parser hunts for a start byte, sums and counters cleared, registers
//   at address 0, control 0x81, max length 0x60.
// Stall: while res is held off, the result register keeps its value and
//   the input register takes one more byte if it is empty, then rx.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_reply_frame_parser
	import mrfp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	mrfp_rx_if.sink    rx,
	mrfp_res_if.source res,
	mrfp_cfg_if.sink   cfg
);

	cfg_t      cfg_vals;
	item_t     in_item;
	item_t     item_s1;
	pipe_ctl_t ctl;
	result_t   result;
	result_t   result_q;
	logic      advance;

	// config port never stalls
	assign cfg.ready = 1'b1;

	mrfp_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_vals)
	);

	assign in_item.rx_byte = rx.rx_byte;
	assign in_item.restart = rx.restart;

	// stage 1: byte request register
	mrfp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.in_item  (in_item),
		.advance  (advance),
		.ctl      (ctl),
		.item_s1  (item_s1)
	);

	// frame state; updates only when the byte moves into the result register
	mrfp_parse_core u_parse_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.item_s1 (item_s1),
		.cfg     (cfg_vals),
		.result  (result)
	);

	// stage 2: result register
	mrfp_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.result    (result),
		.advance   (advance),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.result_q  (result_q)
	);

	assign res.status     = result_q.status;
	assign res.data_valid = result_q.data_valid;
	assign res.data_index = result_q.data_index;
	assign res.data_value = result_q.data_value;
	assign res.identifier = result_q.identifier;
	assign res.reply_len  = result_q.reply_len;

endmodule

`default_nettype wire

@@ hdl/mrfp_checker.sv @@
// ----------------------------------------------------------------------------
// mrfp_checker
// Port-level checks on the result channel of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfp_checker
	import mrfp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [3:0]  status,
	input wire logic        data_valid,
	input wire logic [7:0]  data_index,
	input wire logic [7:0]  data_value,
	input wire logic [15:0] identifier,
	input wire logic [7:0]  reply_len
);

	// a held result is not withdrawn
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// payload bytes only come out mid-frame
	a_data_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && data_valid |-> status == ST_BUSY)
		else $error("payload byte with final status");

	// frame summary only on a good frame
	a_summary_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_OK |-> identifier == 16'h0 && reply_len == 8'h0)
		else $error("frame summary outside good frame");

	// payload fields quiet without a payload byte
	a_data_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !data_valid |-> data_index == 8'h0 && data_value == 8'h0)
		else $error("payload fields set without payload byte");

endmodule

bind meter_reply_frame_parser mrfp_checker u_mrfp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.status     (res.status),
	.data_valid (res.data_valid),
	.data_index (res.data_index),
	.data_value (res.data_value),
	.identifier (res.identifier),
	.reply_len  (res.reply_len)
);

`default_nettype wire
